>>> hdl/battery_band_power_policy_defines.svh
// Assertion macros for the battery band power policy block.
// Used by files that carry concurrent checks; expects clk and rst in scope.
`ifndef BATTERY_BAND_POWER_POLICY_DEFINES_SVH
`define BATTERY_BAND_POWER_POLICY_DEFINES_SVH

`ifndef ASSERT_OFF
// check that is masked while reset is high
`define BBPP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check that also holds across reset
`define BBPP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BBPP_ASSERT(lbl, prop, msg)
`define BBPP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> hdl/bbpp_pkg.sv
// Shared types, constants and band helpers for the battery band power policy.
// No dependencies.
package bbpp_pkg;

  localparam int unsigned PctW  = 7;
  localparam int unsigned TmoW  = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 32;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_BRIGHT_HIGH   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_BRIGHT_MID    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_BRIGHT_LOW    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_BRIGHT_FLOOR  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_TIMEOUT_LONG  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_TIMEOUT_MID   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_TIMEOUT_SHORT = 3'd6;

  // command codes
  localparam logic CMD_BATTERY = 1'b0;
  localparam logic CMD_MANUAL  = 1'b1;

  // register reset values
  localparam logic [PctW-1:0] RST_BRIGHT_HIGH   = 7'd70;
  localparam logic [PctW-1:0] RST_BRIGHT_MID    = 7'd50;
  localparam logic [PctW-1:0] RST_BRIGHT_LOW    = 7'd30;
  localparam logic [PctW-1:0] RST_BRIGHT_FLOOR  = 7'd20;
  localparam logic [TmoW-1:0] RST_TIMEOUT_LONG  = 16'd15000;
  localparam logic [TmoW-1:0] RST_TIMEOUT_MID   = 16'd10000;
  localparam logic [TmoW-1:0] RST_TIMEOUT_SHORT = 16'd5000;

  // battery thresholds
  localparam logic [PctW-1:0] BATT_HIGH     = 7'd70;
  localparam logic [PctW-1:0] BATT_MID      = 7'd40;
  localparam logic [PctW-1:0] BATT_LOW      = 7'd20;
  localparam logic [PctW-1:0] BATT_RADIO_ON = 7'd25;
  localparam logic [PctW-1:0] REQ_MIN       = 7'd10;
  localparam logic [PctW-1:0] REQ_MAX       = 7'd100;

  typedef enum logic [1:0] {
    BAND_FLOOR = 2'd0,
    BAND_LOW   = 2'd1,
    BAND_MID   = 2'd2,
    BAND_HIGH  = 2'd3
  } bbpp_band_t;

  typedef struct packed {
    logic [PctW-1:0] bright_high;
    logic [PctW-1:0] bright_mid;
    logic [PctW-1:0] bright_low;
    logic [PctW-1:0] bright_floor;
    logic [TmoW-1:0] timeout_long;
    logic [TmoW-1:0] timeout_mid;
    logic [TmoW-1:0] timeout_short;
  } bbpp_cfg_t;

  typedef struct packed {
    logic [PctW-1:0] bright;
    logic [TmoW-1:0] timeout;
    logic            ovr_active;
    logic [PctW-1:0] ovr_batt;
    logic [PctW-1:0] ovr_bright;
    logic            radio;
  } bbpp_state_t;

  typedef struct packed {
    logic            command;
    logic [PctW-1:0] batt;
    logic [PctW-1:0] req;
  } bbpp_item_t;

  typedef struct packed {
    logic            status;
    logic            touch;
    logic            radio;
    logic [TmoW-1:0] timeout;
    logic            changed;
    logic [PctW-1:0] bright;
  } bbpp_result_t;

  function automatic bbpp_band_t band_of(input logic [PctW-1:0] batt);
    bbpp_band_t b;
    if (batt >= BATT_HIGH)     b = BAND_HIGH;
    else if (batt >= BATT_MID) b = BAND_MID;
    else if (batt >= BATT_LOW) b = BAND_LOW;
    else                       b = BAND_FLOOR;
    return b;
  endfunction

endpackage

>>> hdl/bbpp_calc.sv
// Next-state and result logic for one item of the battery band power policy.
// Depends on bbpp_pkg.
module bbpp_calc (
  input  bbpp_pkg::bbpp_cfg_t    cfg,
  input  bbpp_pkg::bbpp_state_t  state,
  input  bbpp_pkg::bbpp_item_t   item,
  output bbpp_pkg::bbpp_state_t  state_next,
  output bbpp_pkg::bbpp_result_t result
);
  import bbpp_pkg::*;

  bbpp_band_t      band;
  logic            keep_ovr;
  logic [PctW-1:0] target;
  logic            changed;
  logic            bad_req;

  assign band     = band_of(item.batt);
  assign keep_ovr = (band != BAND_FLOOR) && state.ovr_active &&
                    (band_of(state.ovr_batt) == band);
  assign bad_req  = (item.req < REQ_MIN) || (item.req > REQ_MAX);

  always_comb begin
    if (keep_ovr) begin
      target = state.ovr_bright;
    end else begin
      case (band)
        BAND_HIGH: target = cfg.bright_high;
        BAND_MID:  target = cfg.bright_mid;
        BAND_LOW:  target = cfg.bright_low;
        default:   target = cfg.bright_floor;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    changed    = 1'b0;
    if (item.command == CMD_BATTERY) begin
      if (!keep_ovr) begin
        state_next.ovr_active = 1'b0;
        state_next.ovr_batt   = '0;
        state_next.ovr_bright = '0;
      end
      changed           = (target != state.bright);
      state_next.bright = target;
      if (item.batt >= BATT_HIGH)     state_next.timeout = cfg.timeout_long;
      else if (item.batt > BATT_LOW)  state_next.timeout = cfg.timeout_mid;
      else                            state_next.timeout = cfg.timeout_short;
      // hysteresis: hold radio between the two thresholds
      if (item.batt <= BATT_LOW)           state_next.radio = 1'b0;
      else if (item.batt >= BATT_RADIO_ON) state_next.radio = 1'b1;
    end else if (!bad_req) begin
      state_next.ovr_active = 1'b1;
      state_next.ovr_batt   = item.batt;
      state_next.ovr_bright = item.req;
      state_next.bright     = item.req;
      changed               = 1'b1;
    end
  end

  always_comb begin
    result.bright  = state_next.bright;
    result.changed = changed;
    result.timeout = state_next.timeout;
    result.radio   = state_next.radio;
    result.touch   = (item.batt >= BATT_LOW);
    result.status  = (item.command == CMD_MANUAL) && bad_req;
  end

endmodule

>>> hdl/battery_band_power_policy.sv
// Top level of the battery band power policy: input register, policy logic,
// result register and configuration registers. Depends on bbpp_pkg, bbpp_calc.
//
//  channel  dir  signals                      content
//  s_*      in   s_tvalid s_tready s_tdata    item: battery, request; tuser = command
//  m_*      out  m_tvalid m_tready m_tdata    result of one item
//  cfg_*    in   cfg_we cfg_index cfg_data    configuration register write
//
// One item per cycle sustained while results are taken; an accepted item is held in
// the input register, then its result is loaded into the result register and shows
// on m_* until it is taken.
// Reset clears the policy state, the valid flags and restores register defaults.
// A stalled result holds the result register; the input register then fills
// and s_tready drops until the result is taken.
`include "battery_band_power_policy_defines.svh"

module battery_band_power_policy (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [6:0] battery_percent, [13:7] brightness_request, [15:14] zero
  input  logic [bbpp_pkg::InDataW-1:0]        s_tdata,
  // [0] command
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [6:0] brightness, [7] brightness_changed, [23:8] display timeout in ms,
  // [24] radio_enable, [25] touch_enable, [26] status, [31:27] zero
  output logic [bbpp_pkg::OutDataW-1:0]       m_tdata,
  input  logic                                cfg_we,
  input  logic [bbpp_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [bbpp_pkg::CfgDataW-1:0]       cfg_data
);
  import bbpp_pkg::*;

  bbpp_cfg_t    cfg;
  bbpp_state_t  state;
  bbpp_state_t  state_next;
  bbpp_item_t   in_item;
  logic         in_valid;
  bbpp_result_t result;
  bbpp_result_t out_res;
  logic         out_valid;
  logic         advance;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OutDataW - $bits(bbpp_result_t)){1'b0}}, out_res};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bright_high   <= RST_BRIGHT_HIGH;
      cfg.bright_mid    <= RST_BRIGHT_MID;
      cfg.bright_low    <= RST_BRIGHT_LOW;
      cfg.bright_floor  <= RST_BRIGHT_FLOOR;
      cfg.timeout_long  <= RST_TIMEOUT_LONG;
      cfg.timeout_mid   <= RST_TIMEOUT_MID;
      cfg.timeout_short <= RST_TIMEOUT_SHORT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BRIGHT_HIGH:   cfg.bright_high   <= cfg_data[PctW-1:0];
        REG_BRIGHT_MID:    cfg.bright_mid    <= cfg_data[PctW-1:0];
        REG_BRIGHT_LOW:    cfg.bright_low    <= cfg_data[PctW-1:0];
        REG_BRIGHT_FLOOR:  cfg.bright_floor  <= cfg_data[PctW-1:0];
        REG_TIMEOUT_LONG:  cfg.timeout_long  <= cfg_data[TmoW-1:0];
        REG_TIMEOUT_MID:   cfg.timeout_mid   <= cfg_data[TmoW-1:0];
        REG_TIMEOUT_SHORT: cfg.timeout_short <= cfg_data[TmoW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_item.command <= s_tuser;
      in_item.batt    <= s_tdata[PctW-1:0];
      in_item.req     <= s_tdata[2*PctW-1:PctW];
    end
  end

  bbpp_calc u_calc (
    .cfg        (cfg),
    .state      (state),
    .item       (in_item),
    .state_next (state_next),
    .result     (result)
  );

  // policy state advances together with the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        state <= state_next;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      out_res <= result;
    end
  end

  `BBPP_ASSERT(a_ovr_range, state.ovr_active |-> (state.ovr_bright >= REQ_MIN && state.ovr_bright <= REQ_MAX), "override brightness outside 10..100")
  `BBPP_ASSERT(a_radio_off, (advance && in_item.command == CMD_BATTERY && in_item.batt <= BATT_LOW) |=> !state.radio, "radio on after low battery update")
  `BBPP_ASSERT(a_status_nochg, (out_valid && out_res.status) |-> !out_res.changed, "rejected request marked as changed")
  `BBPP_ASSERT_ALWAYS(a_rst_clear, $past(rst) |-> (!out_valid && !in_valid && !state.ovr_active), "valid or override set after reset")

endmodule

>>> tb/tb.sv
// Self-checking bench for battery_band_power_policy: random and directed items on the
// stream ports, reconfiguration between phases, results checked against a policy predictor.
// Depends on bbpp_pkg and the battery_band_power_policy RTL.
module tb;
  import bbpp_pkg::*;

  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_ITEMS = 275;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned REG_TOTAL   = 7;

  class policy_checker;
    bbpp_cfg_t       regs;
    logic [PctW-1:0] bright_now;
    logic [TmoW-1:0] timeout_now;
    logic            ovr_on;
    logic [PctW-1:0] ovr_batt;
    logic [PctW-1:0] ovr_bright;
    logic            radio_on;
    bbpp_result_t    outputs_due[$];
    int unsigned     mismatches;

    function new();
      regs.bright_high   = RST_BRIGHT_HIGH;
      regs.bright_mid    = RST_BRIGHT_MID;
      regs.bright_low    = RST_BRIGHT_LOW;
      regs.bright_floor  = RST_BRIGHT_FLOOR;
      regs.timeout_long  = RST_TIMEOUT_LONG;
      regs.timeout_mid   = RST_TIMEOUT_MID;
      regs.timeout_short = RST_TIMEOUT_SHORT;
      bright_now  = '0;
      timeout_now = '0;
      ovr_on      = 1'b0;
      ovr_batt    = '0;
      ovr_bright  = '0;
      radio_on    = 1'b0;
      mismatches  = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        REG_BRIGHT_HIGH:   regs.bright_high   = val[PctW-1:0];
        REG_BRIGHT_MID:    regs.bright_mid    = val[PctW-1:0];
        REG_BRIGHT_LOW:    regs.bright_low    = val[PctW-1:0];
        REG_BRIGHT_FLOOR:  regs.bright_floor  = val[PctW-1:0];
        REG_TIMEOUT_LONG:  regs.timeout_long  = val;
        REG_TIMEOUT_MID:   regs.timeout_mid   = val;
        REG_TIMEOUT_SHORT: regs.timeout_short = val;
        default: ;
      endcase
    endfunction

    function bbpp_band_t battery_band(logic [PctW-1:0] batt);
      if (batt >= BATT_HIGH) return BAND_HIGH;
      if (batt >= BATT_MID) return BAND_MID;
      if (batt >= BATT_LOW) return BAND_LOW;
      return BAND_FLOOR;
    endfunction

    function void take_item(logic cmd, logic [PctW-1:0] batt, logic [PctW-1:0] req);
      bbpp_result_t    want;
      bbpp_band_t      band;
      logic [PctW-1:0] target;
      want = '0;
      if (cmd == CMD_BATTERY) begin
        band = battery_band(batt);
        // keep the override only inside the band it was set in, never in the floor band
        if (band != BAND_FLOOR && ovr_on && battery_band(ovr_batt) == band) begin
          target = ovr_bright;
        end else begin
          ovr_on     = 1'b0;
          ovr_batt   = '0;
          ovr_bright = '0;
          case (band)
            BAND_HIGH: target = regs.bright_high;
            BAND_MID:  target = regs.bright_mid;
            BAND_LOW:  target = regs.bright_low;
            default:   target = regs.bright_floor;
          endcase
        end
        if (target != bright_now) begin
          bright_now   = target;
          want.changed = 1'b1;
        end
        if (batt >= BATT_HIGH) timeout_now = regs.timeout_long;
        else if (batt > BATT_LOW) timeout_now = regs.timeout_mid;
        else timeout_now = regs.timeout_short;
        // hysteresis: hold the radio between the two thresholds
        if (batt <= BATT_LOW) radio_on = 1'b0;
        else if (batt >= BATT_RADIO_ON) radio_on = 1'b1;
      end else if (req < REQ_MIN || req > REQ_MAX) begin
        want.status = 1'b1;
      end else begin
        ovr_on       = 1'b1;
        ovr_batt     = batt;
        ovr_bright   = req;
        bright_now   = req;
        want.changed = 1'b1;
      end
      want.bright  = bright_now;
      want.timeout = timeout_now;
      want.radio   = radio_on;
      want.touch   = (batt >= BATT_LOW);
      outputs_due.push_back(want);
    endfunction

    function void check_result(logic [OutDataW-1:0] data);
      bbpp_result_t seen;
      bbpp_result_t want;
      seen.bright  = data[PctW-1:0];
      seen.changed = data[PctW];
      seen.timeout = data[PctW+TmoW:PctW+1];
      seen.radio   = data[PctW+TmoW+1];
      seen.touch   = data[PctW+TmoW+2];
      seen.status  = data[PctW+TmoW+3];
      if (outputs_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result %h with nothing pending", data);
        return;
      end
      want = outputs_due.pop_front();
      if (seen.bright !== want.bright || seen.changed !== want.changed ||
          seen.timeout !== want.timeout || seen.radio !== want.radio ||
          seen.touch !== want.touch || seen.status !== want.status) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("bright/changed/timeout/radio/touch/status exp %0d/%0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d/%0d",
                   want.bright, want.changed, want.timeout, want.radio, want.touch,
                   want.status, seen.bright, seen.changed, seen.timeout, seen.radio,
                   seen.touch, seen.status);
      end
    endfunction

    function int unsigned outstanding();
      return outputs_due.size();
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [InDataW-1:0]   s_tdata   = '0;
  logic                 s_tuser   = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b1;
  logic [OutDataW-1:0]  m_tdata;
  logic                 cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data  = '0;

  policy_checker        chk;
  bit                   gaps_on     = 1'b1;
  int unsigned          idle_cycles = 0;
  int unsigned          hold_left   = 0;
  logic [PctW-1:0]      last_batt   = 7'd50;
  logic [CfgDataW-1:0]  cfg_vals [REG_TOTAL];
  int                   band_edges [12] = '{0, 19, 20, 21, 24, 25, 39, 40, 69, 70, 100, 127};

  battery_band_power_policy dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // stall the result side in short bursts
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      hold_left = $urandom_range(0, 2);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // note accepted items before checking results taken at the same edge
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (s_tvalid && s_tready)
        chk.take_item(s_tuser, s_tdata[PctW-1:0], s_tdata[2*PctW-1:PctW]);
      if (m_tvalid && m_tready)
        chk.check_result(m_tdata);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_item(input logic cmd, input logic [PctW-1:0] batt,
                           input logic [PctW-1:0] req);
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {{(InDataW-2*PctW){1'b0}}, req, batt};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // drop valid and let every pending result come back
  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (chk.outstanding() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_config;
    for (int i = 0; i < REG_TOTAL; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= i[CfgIdxW-1:0];
      cfg_data  <= cfg_vals[i];
      @(posedge clk);
      chk.set_reg(i[CfgIdxW-1:0], cfg_vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic pick_item(output logic cmd, output logic [PctW-1:0] batt,
                           output logic [PctW-1:0] req);
    int b;
    int sel;
    sel = int'($urandom_range(0, 9));
    // half the time drift near the last reading so overrides live through several updates
    if (sel < 5) b = int'(last_batt) + int'($urandom_range(0, 8)) - 4;
    else if (sel < 8) b = band_edges[$urandom_range(0, 11)] + int'($urandom_range(0, 2)) - 1;
    else b = int'($urandom_range(0, 127));
    if (b < 0) b = 0;
    if (b > 127) b = 127;
    batt = b[PctW-1:0];
    last_batt = batt;
    cmd = ($urandom_range(0, 99) < 35) ? CMD_MANUAL : CMD_BATTERY;
    if ($urandom_range(0, 6) == 0) req = PctW'($urandom_range(0, 127));
    else req = PctW'($urandom_range(REQ_MIN, REQ_MAX));
  endtask

  initial begin
    logic            cmd;
    logic [PctW-1:0] batt;
    logic [PctW-1:0] req;
    chk = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // bands, radio hysteresis, battery above full scale
    send_item(CMD_BATTERY, 7'd100, 7'd0);
    send_item(CMD_BATTERY, 7'd127, 7'd0);
    send_item(CMD_BATTERY, 7'd0,   7'd0);
    send_item(CMD_BATTERY, 7'd22,  7'd0);
    send_item(CMD_BATTERY, 7'd25,  7'd0);
    send_item(CMD_BATTERY, 7'd22,  7'd0);
    send_item(CMD_BATTERY, 7'd20,  7'd0);
    send_item(CMD_BATTERY, 7'd24,  7'd0);
    send_item(CMD_BATTERY, 7'd19,  7'd0);
    send_item(CMD_BATTERY, 7'd21,  7'd0);
    send_item(CMD_BATTERY, 7'd39,  7'd0);
    send_item(CMD_BATTERY, 7'd40,  7'd0);
    send_item(CMD_BATTERY, 7'd69,  7'd0);
    send_item(CMD_BATTERY, 7'd70,  7'd0);
    // rejected requests, then overrides kept, cleared and cleared in the floor band
    send_item(CMD_MANUAL,  7'd50,  7'd9);
    send_item(CMD_MANUAL,  7'd50,  7'd101);
    send_item(CMD_MANUAL,  7'd50,  7'd127);
    send_item(CMD_MANUAL,  7'd50,  7'd10);
    send_item(CMD_MANUAL,  7'd50,  7'd100);
    send_item(CMD_MANUAL,  7'd50,  7'd100);
    send_item(CMD_BATTERY, 7'd45,  7'd0);
    send_item(CMD_BATTERY, 7'd30,  7'd0);
    send_item(CMD_MANUAL,  7'd10,  7'd80);
    send_item(CMD_BATTERY, 7'd15,  7'd0);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: begin
          for (int i = 0; i < REG_TOTAL; i++) cfg_vals[i] = '0;
        end
        1: begin
          for (int i = 0; i < REG_TOTAL; i++) cfg_vals[i] = '1;
        end
        2: begin
          cfg_vals[REG_BRIGHT_HIGH]   = CfgDataW'(RST_BRIGHT_HIGH);
          cfg_vals[REG_BRIGHT_MID]    = CfgDataW'(RST_BRIGHT_MID);
          cfg_vals[REG_BRIGHT_LOW]    = CfgDataW'(RST_BRIGHT_LOW);
          cfg_vals[REG_BRIGHT_FLOOR]  = CfgDataW'(RST_BRIGHT_FLOOR);
          cfg_vals[REG_TIMEOUT_LONG]  = RST_TIMEOUT_LONG;
          cfg_vals[REG_TIMEOUT_MID]   = RST_TIMEOUT_MID;
          cfg_vals[REG_TIMEOUT_SHORT] = RST_TIMEOUT_SHORT;
        end
        3: begin
          for (int i = 0; i < REG_TOTAL; i++) cfg_vals[i] = CfgDataW'($urandom_range(0, 65535));
        end
        default: begin
          cfg_vals[REG_BRIGHT_HIGH]   = CfgDataW'($urandom_range(0, 100));
          cfg_vals[REG_BRIGHT_MID]    = CfgDataW'($urandom_range(0, 100));
          cfg_vals[REG_BRIGHT_LOW]    = CfgDataW'($urandom_range(0, 100));
          cfg_vals[REG_BRIGHT_FLOOR]  = CfgDataW'($urandom_range(0, 100));
          cfg_vals[REG_TIMEOUT_LONG]  = CfgDataW'($urandom_range(0, 65535));
          cfg_vals[REG_TIMEOUT_MID]   = CfgDataW'($urandom_range(0, 65535));
          cfg_vals[REG_TIMEOUT_SHORT] = CfgDataW'($urandom_range(0, 65535));
        end
      endcase
      write_config();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == PHASES - 1) gaps_on = 1'b0;
        else if ($urandom_range(0, 59) == 0) gaps_on = !gaps_on;
        pick_item(cmd, batt, req);
        send_item(cmd, batt, req);
      end
    end

    drain();
    repeat (5) @(posedge clk);
    if (chk.mismatches == 0 && chk.outstanding() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+hdl
hdl/bbpp_pkg.sv
hdl/bbpp_calc.sv
hdl/battery_band_power_policy.sv
tb/tb.sv
